@@ sv/pagg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the preferential attachment graph grower.
// Used by the output register and the top level; depends on nothing.
package pagg_pkg;

  localparam int unsigned RV_W     = 31;
  localparam int unsigned ATTACH_W = 4;
  localparam int unsigned LIMIT_W  = 15;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_IW   = 1;

  localparam logic [ATTACH_W-1:0] ATTACH_RST = 4'd3;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = 15'd1000;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  localparam logic [CFG_IW-1:0] CFG_ATTACH = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_LIMIT  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_EDGE    = 2'd0,
    ST_BUILT   = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

endpackage

@@ sv/pagg_serial_mod.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// Stand-alone; used by the top level for the draw index.
module pagg_serial_mod #(
  parameter int unsigned DIVIDEND_W = 31,
  parameter int unsigned DIVISOR_W  = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVISOR_W-1:0]  rem_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] sh_q, sh_d;
  logic [DIVISOR_W-1:0]  div_q, div_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;

  assign trial = {rem_q, sh_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};

  always_comb begin
    sh_d   = sh_q;
    div_d  = div_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      sh_d   = dividend_i;
      div_d  = divisor_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVIDEND_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      sh_d = sh_q << 1;
      if (trial >= {1'b0, div_q}) begin
        rem_d = diff[DIVISOR_W-1:0];
      end else begin
        rem_d = trial[DIVISOR_W-1:0];
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

@@ sv/pagg_out_reg.sv @@
`timescale 1ns / 1ps
// Output register that holds one result word for the master stream.
// Depends on pagg_pkg for the status codes.
module pagg_out_reg
  import pagg_pkg::*;
#(
  parameter int unsigned NODE_BITS = 16,
  parameter int unsigned OUT_DW    = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  status_e              status_i,
  input  logic [NODE_BITS-1:0] new_node_i,
  input  logic [NODE_BITS-1:0] target_node_i,
  input  logic                 last_i,
  output logic                 full_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OUT_DW-1:0]    m_axis_tdata,
  output logic [STATUS_W-1:0]  m_axis_tuser,
  output logic                 m_axis_tlast
);

  logic                 valid_q, valid_d;
  status_e              status_q;
  logic [NODE_BITS-1:0] new_q;
  logic [NODE_BITS-1:0] target_q;
  logic                 last_q;

  always_comb begin
    valid_d = valid_q;
    if (m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      status_q <= status_i;
      new_q    <= new_node_i;
      target_q <= target_node_i;
      last_q   <= last_i;
    end
  end

  assign full_o        = valid_q;
  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_DW'({target_q, new_q});
  assign m_axis_tuser  = status_q;
  assign m_axis_tlast  = last_q;

endmodule

@@ sv/preferential_attachment_graph_grower.sv @@
`timescale 1ns / 1ps
// Top level of the preferential attachment graph grower: control, endpoint list
// memory and chosen set. Depends on pagg_pkg, pagg_serial_mod and pagg_out_reg.
//
//   Channel   Direction  Word contents
//   s_axis    in         tuser: opcode; tdata: random_value
//   m_axis    out        tuser: status; tdata: new_node, target_node; tlast: last
//   cfg       in         cfg_index_i: register index; cfg_data_i: value
//
// A draw that adds a pick loads the bit-serial remainder unit, runs it over the
// dividend bits, reads the list and checks the chosen set; a completing draw then
// appends two list entries and emits a word per edge. A start writes the initial
// list of m*(m+1) entries, one per cycle. Reset clears all control state but not the
// list memory. A stalled output holds the sequencer in place until the word is taken.
module preferential_attachment_graph_grower
  import pagg_pkg::*;
#(
  parameter int unsigned LIST_DEPTH = 65536,
  parameter int unsigned MAX_ATTACH = 8,
  parameter int unsigned NODE_BITS  = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // Bits from the lowest: random_value (31), zero pad (1).
  input  logic [31:0]                      s_axis_tdata,
  // Bits from the lowest: opcode (1).
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // Bits from the lowest: new_node, target_node, zero pad to whole bytes.
  output logic [((2*NODE_BITS+7)/8)*8-1:0] m_axis_tdata,
  // Bits from the lowest: status (2).
  output logic [STATUS_W-1:0]              m_axis_tuser,
  output logic                             m_axis_tlast,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [CFG_IW-1:0]                cfg_index_i,
  input  logic [LIMIT_W-1:0]               cfg_data_i
);

  localparam int unsigned OUT_DW = ((2*NODE_BITS+7)/8)*8;
  localparam int unsigned AW     = $clog2(LIST_DEPTH);
  localparam int unsigned CW     = $clog2(LIST_DEPTH + 1);
  localparam int unsigned MW     = $clog2(MAX_ATTACH + 1);
  localparam int unsigned CIW    = (MAX_ATTACH > 1) ? $clog2(MAX_ATTACH) : 1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_FILL     = 4'd1;
  localparam logic [3:0] S_BUILT    = 4'd2;
  localparam logic [3:0] S_REFUSE   = 4'd3;
  localparam logic [3:0] S_MOD      = 4'd4;
  localparam logic [3:0] S_CHECK    = 4'd5;
  localparam logic [3:0] S_APPEND_A = 4'd6;
  localparam logic [3:0] S_APPEND_B = 4'd7;
  localparam logic [3:0] S_EMIT     = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [CW-1:0]        list_cnt_q, list_cnt_d;
  logic [NODE_BITS-1:0] node_cnt_q, node_cnt_d;
  logic [LIMIT_W-1:0]   steps_q, steps_d;
  logic [MW-1:0]        chosen_cnt_q, chosen_cnt_d;
  logic                 ready_q, ready_d;
  logic [ATTACH_W-1:0]  attach_q, attach_d;
  logic [LIMIT_W-1:0]   limit_q, limit_d;
  logic [NODE_BITS-1:0] fill_node_q, fill_node_d;
  logic [MW-1:0]        fill_rep_q, fill_rep_d;
  logic [CIW-1:0]       k_q, k_d;

  logic [NODE_BITS-1:0] chosen_q [MAX_ATTACH];
  logic [NODE_BITS-1:0] mem_q [LIST_DEPTH];
  logic [NODE_BITS-1:0] rd_q;

  logic [MW-1:0]        m_eff;
  logic                 in_acc;
  logic                 refused;
  logic                 mod_start;
  logic                 mod_done;
  logic [CW-1:0]        mod_rem;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [NODE_BITS-1:0] mem_wd;
  logic                 chosen_we;
  logic                 seen;
  logic                 out_load;
  logic                 out_full;
  status_e              out_status;
  logic                 out_last;
  logic [NODE_BITS-1:0] out_new;
  logic [NODE_BITS-1:0] out_target;
  logic [NODE_BITS-1:0] k_target;
  logic                 k_last;

  always_comb begin
    if (attach_q == '0) begin
      m_eff = MW'(1);
    end else if ({1'b0, attach_q} > (ATTACH_W+1)'(MAX_ATTACH)) begin
      m_eff = MW'(MAX_ATTACH);
    end else begin
      m_eff = MW'(attach_q);
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign refused = !ready_q || (list_cnt_q == '0) || (steps_q >= limit_q) ||
                   (({1'b0, list_cnt_q} + (CW+1)'({m_eff, 1'b0})) > (CW+1)'(LIST_DEPTH)) ||
                   (node_cnt_q == '1);

  assign mod_start = in_acc && (s_axis_tuser == OP_DRAW) && !refused &&
                     (chosen_cnt_q < m_eff);

  assign k_target = chosen_q[k_q];
  assign k_last   = (MW'(k_q) == (m_eff - MW'(1)));

  always_comb begin
    seen = 1'b0;
    for (int i = 0; i < MAX_ATTACH; i++) begin
      if ((MW'(i) < chosen_cnt_q) && (chosen_q[i] == rd_q)) begin
        seen = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    list_cnt_d   = list_cnt_q;
    node_cnt_d   = node_cnt_q;
    steps_d      = steps_q;
    chosen_cnt_d = chosen_cnt_q;
    ready_d      = ready_q;
    attach_d     = attach_q;
    limit_d      = limit_q;
    fill_node_d  = fill_node_q;
    fill_rep_d   = fill_rep_q;
    k_d          = k_q;
    mem_we       = 1'b0;
    mem_wa       = list_cnt_q[AW-1:0];
    mem_wd       = fill_node_q;
    chosen_we    = 1'b0;
    out_load     = 1'b0;
    out_status   = ST_EDGE;
    out_new      = '0;
    out_target   = '0;
    out_last     = 1'b1;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ATTACH: attach_d = cfg_data_i[ATTACH_W-1:0];
        CFG_LIMIT:  limit_d  = cfg_data_i;
        default:    limit_d  = limit_q;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == OP_START) begin
            list_cnt_d  = '0;
            fill_node_d = NODE_BITS'(1);
            fill_rep_d  = '0;
            state_d     = S_FILL;
          end else if (refused) begin
            state_d = S_REFUSE;
          end else if (chosen_cnt_q < m_eff) begin
            state_d = S_MOD;
          end else begin
            node_cnt_d = node_cnt_q + NODE_BITS'(1);
            k_d        = '0;
            state_d    = S_APPEND_A;
          end
        end
      end
      S_FILL: begin
        mem_we     = 1'b1;
        list_cnt_d = list_cnt_q + CW'(1);
        fill_rep_d = fill_rep_q + MW'(1);
        if (fill_rep_q == m_eff - MW'(1)) begin
          fill_rep_d  = '0;
          fill_node_d = fill_node_q + NODE_BITS'(1);
          if (fill_node_q == NODE_BITS'(m_eff) + NODE_BITS'(1)) begin
            node_cnt_d   = fill_node_q;
            steps_d      = '0;
            chosen_cnt_d = '0;
            ready_d      = 1'b1;
            state_d      = S_BUILT;
          end
        end
      end
      S_BUILT: begin
        if (!out_full) begin
          out_load   = 1'b1;
          out_status = ST_BUILT;
          state_d    = S_IDLE;
        end
      end
      S_REFUSE: begin
        if (!out_full) begin
          out_load   = 1'b1;
          out_status = ST_REFUSED;
          state_d    = S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        chosen_cnt_d = chosen_cnt_q;
        if (!seen) begin
          chosen_we    = 1'b1;
          chosen_cnt_d = chosen_cnt_q + MW'(1);
        end
        if (chosen_cnt_d < m_eff) begin
          state_d = S_IDLE;
        end else begin
          node_cnt_d = node_cnt_q + NODE_BITS'(1);
          k_d        = '0;
          state_d    = S_APPEND_A;
        end
      end
      S_APPEND_A: begin
        mem_we     = 1'b1;
        mem_wd     = node_cnt_q;
        list_cnt_d = list_cnt_q + CW'(1);
        state_d    = S_APPEND_B;
      end
      S_APPEND_B: begin
        mem_we     = 1'b1;
        mem_wd     = k_target;
        list_cnt_d = list_cnt_q + CW'(1);
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (!out_full) begin
          out_load   = 1'b1;
          out_status = ST_EDGE;
          out_new    = node_cnt_q;
          out_target = k_target;
          out_last   = k_last;
          if (k_last) begin
            chosen_cnt_d = '0;
            steps_d      = steps_q + LIMIT_W'(1);
            state_d      = S_IDLE;
          end else begin
            k_d     = k_q + CIW'(1);
            state_d = S_APPEND_A;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      list_cnt_q   <= '0;
      node_cnt_q   <= '0;
      steps_q      <= '0;
      chosen_cnt_q <= '0;
      ready_q      <= 1'b0;
      attach_q     <= ATTACH_RST;
      limit_q      <= LIMIT_RST;
      fill_node_q  <= '0;
      fill_rep_q   <= '0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      list_cnt_q   <= list_cnt_d;
      node_cnt_q   <= node_cnt_d;
      steps_q      <= steps_d;
      chosen_cnt_q <= chosen_cnt_d;
      ready_q      <= ready_d;
      attach_q     <= attach_d;
      limit_q      <= limit_d;
      fill_node_q  <= fill_node_d;
      fill_rep_q   <= fill_rep_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chosen_we) begin
      chosen_q[chosen_cnt_q[CIW-1:0]] <= rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mod_done) begin
      rd_q <= mem_q[mod_rem[AW-1:0]];
    end
  end

  pagg_serial_mod #(
    .DIVIDEND_W (RV_W),
    .DIVISOR_W  (CW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (s_axis_tdata[RV_W-1:0]),
    .divisor_i  (list_cnt_q),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  pagg_out_reg #(
    .NODE_BITS (NODE_BITS),
    .OUT_DW    (OUT_DW)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (out_load),
    .status_i      (out_status),
    .new_node_i    (out_new),
    .target_node_i (out_target),
    .last_i        (out_last),
    .full_o        (out_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

`ifndef SYNTH
  a_chosen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chosen_cnt_q <= MW'(MAX_ATTACH))
    else $error("chosen set count exceeds its capacity");

  a_list_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, list_cnt_q} <= (CW+1)'(LIST_DEPTH))
    else $error("endpoint list count exceeds the list depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> !out_full)
    else $error("result loaded into a full output register");

  a_mod_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("remainder finished outside the draw sequence");

  a_mod_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_start |=> (state_q == S_MOD))
    else $error("remainder started without entering the draw sequence");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the preferential attachment graph grower, driven and checked
// through its stream ports, with an in-bench predictor of the endpoint list.
// Depends on pagg_pkg and preferential_attachment_graph_grower.
module tb_top;
  import pagg_pkg::*;

  localparam int unsigned LIST_DEPTH    = 65536;
  localparam int unsigned MAX_LINKS     = 8;
  localparam int unsigned NODE_MAX      = 65535;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned CYCLE_LIMIT   = 4000000;

  typedef struct packed {
    logic        op;
    logic [30:0] rv;
  } draw_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] new_node;
    logic [15:0] target;
    logic        last;
  } edge_word_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_START;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [CFG_IW-1:0]  cfg_index_i = CFG_ATTACH;
  logic [LIMIT_W-1:0] cfg_data_i = '0;

  // Predictor state of the graph.
  logic [15:0]       ep_list [0:LIST_DEPTH-1];
  int unsigned       ep_count = 0;
  int unsigned       node_cnt = 0;
  int unsigned       steps = 0;
  logic [15:0]       chosen [0:MAX_LINKS-1];
  int unsigned       n_chosen = 0;
  bit                graph_ok = 1'b0;
  logic [ATTACH_W-1:0] attach_reg = ATTACH_RST;
  logic [LIMIT_W-1:0]  limit_reg = LIMIT_RST;

  draw_t      draw_q[$];
  edge_word_t edge_word_q[$];

  bit          in_fire = 1'b0;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 1;
  bit          rdy_state = 1'b1;
  int unsigned rdy_left = 0;
  int unsigned cycles = 0;
  int unsigned mism = 0;
  int unsigned n_taken = 0;
  int unsigned n_edges = 0;
  int unsigned n_built = 0;
  int unsigned n_refused = 0;

  preferential_attachment_graph_grower u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned eff_attach();
    if (attach_reg == 0) return 1;
    if (attach_reg > MAX_LINKS) return MAX_LINKS;
    return 32'(attach_reg);
  endfunction

  function automatic logic [30:0] rand_rv();
    case ($urandom_range(0, 9))
      0: return 31'h0;
      1: return 31'h7FFF_FFFF;
      2: return 31'($urandom_range(0, 255));
      default: return 31'($urandom);
    endcase
  endfunction

  task automatic emit_status(input status_e st);
    edge_word_q.push_back('{st, 16'd0, 16'd0, 1'b1});
  endtask

  task automatic grow_graph(input logic op, input logic [30:0] rv);
    int unsigned m;
    int unsigned n;
    int unsigned k;
    logic [15:0] pick;
    bit          seen;
    m = eff_attach();
    if (op == OP_START) begin
      ep_count = 0;
      for (n = 1; n <= m + 1; n++) begin
        for (k = 0; k < m; k++) begin
          ep_list[ep_count] = 16'(n);
          ep_count++;
        end
      end
      node_cnt = m + 1;
      steps = 0;
      n_chosen = 0;
      graph_ok = 1'b1;
      emit_status(ST_BUILT);
    end else if (!graph_ok || ep_count == 0 || steps >= limit_reg ||
                 ep_count + 2 * m > LIST_DEPTH || node_cnt >= NODE_MAX) begin
      emit_status(ST_REFUSED);
    end else begin
      if (n_chosen < m) begin
        pick = ep_list[rv % ep_count];
        seen = 1'b0;
        for (k = 0; k < n_chosen; k++) begin
          if (chosen[k] == pick) seen = 1'b1;
        end
        if (!seen && n_chosen < MAX_LINKS) begin
          chosen[n_chosen] = pick;
          n_chosen++;
        end
      end
      if (n_chosen >= m) begin
        node_cnt++;
        for (k = 0; k < m; k++) begin
          ep_list[ep_count] = node_cnt[15:0];
          ep_list[ep_count + 1] = chosen[k];
          ep_count += 2;
          edge_word_q.push_back('{ST_EDGE, node_cnt[15:0], chosen[k], k + 1 == m});
        end
        n_chosen = 0;
        steps++;
      end
    end
  endtask

  // Word driver with bursts and gaps.
  always @(negedge clk_i) begin
    draw_t nxt;
    bit    drive;
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      drive = 1'b0;
      if (send_idle && gap_left > 0) begin
        gap_left--;
      end else if (draw_q.size() != 0) begin
        nxt = draw_q.pop_front();
        drive = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end
      end
      s_axis_tvalid <= drive;
      if (drive) begin
        s_axis_tdata <= {1'b0, nxt.rv};
        s_axis_tuser <= nxt.op;
      end
    end
  end

  // Result side stalls in runs of ready and not ready.
  always @(negedge clk_i) begin
    if (!recv_idle) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rdy_left == 0) begin
        rdy_state = !rdy_state;
        rdy_left = rdy_state ? $urandom_range(1, 12) : $urandom_range(1, 20);
      end else begin
        rdy_left--;
      end
      m_axis_tready <= rdy_state;
    end
  end

  // Monitor: predicts on every accepted input word and checks every result word.
  always @(posedge clk_i) begin
    edge_word_t want;
    in_fire = s_axis_tvalid && s_axis_tready;
    if (in_fire) begin
      grow_graph(s_axis_tuser, s_axis_tdata[30:0]);
      n_taken++;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      if (edge_word_q.size() == 0) begin
        mism++;
        if (mism <= 10)
          $display("Unexpected result word: status %0d new %0d target %0d last %0b",
                   m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
      end else begin
        want = edge_word_q.pop_front();
        case (want.status)
          ST_EDGE:  n_edges++;
          ST_BUILT: n_built++;
          default:  n_refused++;
        endcase
        if (m_axis_tuser !== want.status || m_axis_tdata[15:0] !== want.new_node ||
            m_axis_tdata[31:16] !== want.target || m_axis_tlast !== want.last) begin
          mism++;
          if (mism <= 10)
            $display("Mismatch: expected status %0d new %0d target %0d last %0b, got %0d %0d %0d %0b",
                     want.status, want.new_node, want.target, want.last, m_axis_tuser,
                     m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result words outstanding.",
               cycles, edge_word_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic push_item(input logic op, input logic [30:0] rv);
    draw_q.push_back('{op, rv});
  endtask

  task automatic settle();
    while (draw_q.size() != 0 || s_axis_tvalid || edge_word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IW-1:0] idx, input logic [LIMIT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_ATTACH) attach_reg = val[ATTACH_W-1:0];
    else limit_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_attach(input logic [ATTACH_W-1:0] a);
    cfg_write(CFG_ATTACH, {11'($urandom_range(0, 2047)), a});
  endtask

  initial begin : stimulus
    int unsigned n_rand;
    int unsigned len;
    int unsigned k;
    logic [ATTACH_W-1:0] a;
    logic [LIMIT_W-1:0]  lim;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Draws before any start are refused.
    push_item(OP_DRAW, 31'h0);
    push_item(OP_DRAW, 31'h7FFF_FFFF);
    // Start with three links; a repeated pick adds nothing.
    push_item(OP_START, 31'h7FFF_FFFF);
    push_item(OP_DRAW, 31'd0);
    push_item(OP_DRAW, 31'd3);
    push_item(OP_DRAW, 31'd12);
    push_item(OP_DRAW, 31'd6);
    push_item(OP_DRAW, 31'd0);
    push_item(OP_DRAW, 31'd3);
    settle();
    // Lowering the link count below the picks already held completes the node.
    set_attach(4'd1);
    push_item(OP_DRAW, 31'h7FFF_FFFF);
    settle();
    cfg_write(CFG_LIMIT, 15'd0);
    push_item(OP_DRAW, 31'd5);
    settle();
    set_attach(4'd0);
    push_item(OP_START, 31'd0);
    push_item(OP_DRAW, 31'd1);
    settle();
    cfg_write(CFG_LIMIT, 15'd2);
    push_item(OP_DRAW, 31'd0);
    push_item(OP_DRAW, 31'd1);
    push_item(OP_DRAW, 31'd2);
    settle();
    set_attach(4'd15);
    cfg_write(CFG_LIMIT, 15'h7FFF);
    push_item(OP_START, 31'd9);
    for (k = 0; k < 8; k++) push_item(OP_DRAW, 31'(8 * k));
    settle();

    n_rand = 0;
    while (n_rand < 220) begin
      a = ($urandom_range(0, 3) == 0) ? ATTACH_W'($urandom_range(0, 15)) :
                                        ATTACH_W'($urandom_range(1, 8));
      case ($urandom_range(0, 5))
        0: lim = LIMIT_W'($urandom_range(0, 6));
        1: lim = 15'h7FFF;
        default: lim = LIMIT_W'($urandom_range(10, 60));
      endcase
      set_attach(a);
      cfg_write(CFG_LIMIT, lim);
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      len = $urandom_range(15, 40);
      if ($urandom_range(0, 7) != 0) begin
        push_item(OP_START, rand_rv());
        n_rand++;
      end
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 24) == 0) push_item(OP_START, rand_rv());
        else push_item(OP_DRAW, rand_rv());
      end
      n_rand += len;
      settle();
    end

    while (draw_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (edge_word_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Covered %0d input words and %0d edges, %0d builds, %0d refused draws.",
             n_taken, n_edges, n_built, n_refused);
    $display("Link counts, step limits and stall patterns varied between runs, %0d mismatches.",
             mism);
    if (mism == 0 && edge_word_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ preferential_attachment_graph_grower.f @@
sv/pagg_pkg.sv
sv/pagg_serial_mod.sv
sv/pagg_out_reg.sv
sv/preferential_attachment_graph_grower.sv
bench/tb_top.sv
